[sv/multiprecision_integer_alu_defines.svh]
// Assertion macros shared by the multiprecision ALU RTL.
// Depends on nothing; included by files that assert.
`ifndef MULTIPRECISION_INTEGER_ALU_DEFINES_SVH
`define MULTIPRECISION_INTEGER_ALU_DEFINES_SVH
// Implication checked every clock, disabled during reset.
`define MIA_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication into the following cycle.
`define MIA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[sv/mia_pkg.sv]
// Package for the multiprecision ALU: opcodes and sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mia_pkg;
  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_CMP = 4'd4, OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7,
    OP_NOT = 4'd8, OP_SHL = 4'd9, OP_SHR = 4'd10, OP_ROL = 4'd11,
    OP_ROR = 4'd12, OP_INC = 4'd13, OP_DEC = 4'd14, OP_TEST = 4'd15
  } opcode_t;
  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;
endpackage
`default_nettype wire

[sv/multiprecision_integer_alu.sv]
// Multiprecision unsigned integer ALU, bit-serial datapath.
// Input request: opcode, operand_a, operand_b, bit_count, on valid/stall.
// Result request: value, remainder and flags, on valid/stall.
// One request is worked at a time. It is taken in while idle or while the
// previous result is being taken. Work then runs one bit per cycle over all
// W = 8*OPERAND_BYTES bits (shift registers a and b rotate through a
// one-bit adder or comparator; multiply and divide each use one W-bit
// add/subtract per bit step). Shifts and rotates step one position a cycle,
// bit_count positions in all (capped at W for shifts; a rotate by bit_count
// steps comes to the same as a rotate by bit_count modulo W). The result
// register holds while out_stall is high; no new request is accepted until
// that result leaves. Reset clears the sequencer and out_valid; payload
// registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "multiprecision_integer_alu_defines.svh"
module multiprecision_integer_alu
  import mia_pkg::*;
#(
  parameter int OPERAND_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  input  wire logic [5:0]  in_bit_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_value,
  output logic [63:0]      out_remainder,
  output logic             out_carry_out,
  output logic [1:0]       out_order,
  output logic             out_is_zero,
  output logic             out_is_odd,
  output logic             out_top_bit,
  output logic             out_divide_by_zero
);
  localparam int W  = 8 * OPERAND_BYTES;
  // The step counter holds up to max(W, 63), the larger of W and the longest rotate.
  localparam int CW = 7;
  localparam int MAX_STEPS = (W > 63) ? W : 63;

  state_t        state_r, state_nxt;
  opcode_t       op_r;
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [W:0]    rm_r, rm_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          c_r, c_nxt, nz_r, nz_nxt;
  logic [1:0]    ord_r, ord_nxt;
  logic          ov_r, ov_nxt;
  logic [63:0]   val_r, rem_r;
  logic          co_r, z_r, od_r, tb_r, dz_r;
  logic [1:0]    oo_r;
  logic          fin, take;
  logic [W:0]    rtry;
  logic [W:0]    sum1;
  logic [CW-1:0] steps;
  logic [6:0]    bc_ext;

  assign in_stall = (state_r == ST_RUN) || (ov_r && out_stall);
  assign take     = in_valid && !in_stall;
  assign bc_ext   = {1'b0, in_bit_count};

  always_comb begin
    // Steps needed for a request: W for serial arithmetic, count for shifts and rotates.
    steps = CW'(W);
    case (opcode_t'(in_opcode))
      OP_SHL, OP_SHR: begin
        steps = (bc_ext >= 7'(W)) ? CW'(W) : CW'(bc_ext);
      end
      OP_ROL, OP_ROR: begin
        steps = CW'(bc_ext);
      end
      default: steps = CW'(W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= take ? opcode_t'(in_opcode) : op_r;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    rm_r  <= rm_nxt;
    cnt_r <= cnt_nxt;
    c_r   <= c_nxt;
    nz_r  <= nz_nxt;
    ord_r <= ord_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; b_nxt = b_r; p_nxt = p_r; q_nxt = q_r; rm_nxt = rm_r;
    cnt_nxt = cnt_r; c_nxt = c_r; nz_nxt = nz_r; ord_nxt = ord_r;
    fin  = 1'b0;
    sum1 = '0;
    rtry = '0;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (take) begin
          state_nxt = ST_RUN;
          a_nxt   = in_operand_a[W-1:0];
          b_nxt   = in_operand_b[W-1:0];
          p_nxt   = '0;
          q_nxt   = in_operand_a[W-1:0];
          rm_nxt  = '0;
          cnt_nxt = steps;
          nz_nxt  = 1'b0;
          ord_nxt = ORD_EQ;
          case (opcode_t'(in_opcode))
            OP_SUB, OP_DEC: c_nxt = 1'b1;
            OP_INC:         c_nxt = 1'b1;
            default:        c_nxt = 1'b0;
          endcase
        end
      end
      ST_RUN: begin
        if (cnt_r == '0) begin
          fin = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          case (op_r)
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_AND, OP_OR, OP_XOR, OP_NOT,
            OP_CMP, OP_TEST: begin
              // LSB first: a rotates right, result bit enters at the top.
              logic bb, ab, r;
              ab = a_r[0];
              case (op_r)
                OP_SUB:  bb = ~b_r[0];
                OP_DEC:  bb = 1'b1;
                OP_INC:  bb = 1'b0;
                default: bb = b_r[0];
              endcase
              r = ab ^ bb ^ c_r;
              if (op_r == OP_DEC) begin
                // Borrow chain: c_r is the pending borrow, starting at one.
                r = ab ^ c_r;
                c_nxt = ~ab & c_r;
              end else begin
                c_nxt = (ab & bb) | (ab & c_r) | (bb & c_r);
              end
              case (op_r)
                OP_AND:  r = ab & b_r[0];
                OP_OR:   r = ab | b_r[0];
                OP_XOR:  r = ab ^ b_r[0];
                OP_NOT:  r = ~ab;
                OP_TEST: r = ab;
                default: ;
              endcase
              if (op_r == OP_CMP && ab != b_r[0]) ord_nxt = ab ? ORD_GT : ORD_LT;
              nz_nxt = nz_r | ab;
              a_nxt = {r, a_r[W-1:1]};
              b_nxt = {b_r[0], b_r[W-1:1]};
            end
            OP_MUL: begin
              // MSB-first shift and add: p = 2p + (a top bit ? b : 0).
              sum1  = {1'b0, p_r[W-2:0], 1'b0} + (a_r[W-1] ? {1'b0, b_r} : '0);
              p_nxt = sum1[W-1:0];
              a_nxt = {a_r[W-2:0], 1'b0};
            end
            OP_DIV: begin
              // Restoring division; q holds the dividend shifting into rm.
              rtry = {rm_r[W-1:0], q_r[W-1]} - {1'b0, b_r};
              if (!rtry[W]) begin
                rm_nxt = rtry;
                q_nxt  = {q_r[W-2:0], 1'b1};
              end else begin
                rm_nxt = {rm_r[W-1:0], q_r[W-1]};
                q_nxt  = {q_r[W-2:0], 1'b0};
              end
            end
            OP_SHL: a_nxt = {a_r[W-2:0], 1'b0};
            OP_SHR: a_nxt = {1'b0, a_r[W-1:1]};
            OP_ROL: a_nxt = {a_r[W-2:0], a_r[W-1]};
            default: a_nxt = {a_r[0], a_r[W-1:1]};
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register: loads when the run finishes, drops when taken.
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (fin) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      val_r <= '0; rem_r <= '0; co_r <= 1'b0; oo_r <= '0;
      z_r <= 1'b0; od_r <= 1'b0; tb_r <= 1'b0; dz_r <= 1'b0;
      case (op_r)
        OP_ADD, OP_INC: begin
          val_r <= 64'(a_r); co_r <= c_r;
        end
        OP_SUB, OP_DEC: begin
          val_r <= 64'(a_r); co_r <= ~c_r ^ (op_r == OP_DEC);
        end
        OP_MUL: val_r <= 64'(p_r);
        OP_DIV: begin
          if (b_r == '0) dz_r <= 1'b1;
          else begin
            val_r <= 64'(q_r); rem_r <= 64'(rm_r[W-1:0]);
          end
        end
        OP_CMP: oo_r <= ord_r;
        OP_TEST: begin
          z_r <= ~nz_r; od_r <= a_r[0]; tb_r <= a_r[W-1];
        end
        default: val_r <= 64'(a_r);
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_value          = val_r;
  assign out_remainder      = rem_r;
  assign out_carry_out      = co_r;
  assign out_order          = oo_r;
  assign out_is_zero        = z_r;
  assign out_is_odd         = od_r;
  assign out_top_bit        = tb_r;
  assign out_divide_by_zero = dz_r;

  `MIA_ASSERT_IMP(a_no_take_in_run, clk, rst_n, state_r == ST_RUN, !take)
  `MIA_ASSERT_NEXT(a_fin_valid, clk, rst_n, fin, out_valid)
  `MIA_ASSERT_IMP(a_cnt_bound, clk, rst_n, state_r == ST_RUN, cnt_r <= CW'(MAX_STEPS))
  `MIA_ASSERT_NEXT(a_take_runs, clk, rst_n, take, state_r == ST_RUN)
endmodule
`default_nettype wire

[tb/multiprecision_integer_alu_checker.sv]
// Result checker for the multiprecision ALU: watches both channels, predicts each result
// from the accepted request and compares it field by field. Depends on mia_pkg.
`timescale 1ns / 1ps
module multiprecision_integer_alu_checker
  import mia_pkg::*;
#(
  parameter int OPERAND_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic [5:0]  in_bit_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_value,
  input  logic [63:0] out_remainder,
  input  logic        out_carry_out,
  input  logic [1:0]  out_order,
  input  logic        out_is_zero,
  input  logic        out_is_odd,
  input  logic        out_top_bit,
  input  logic        out_divide_by_zero,
  output int          fail_count,
  output int          pending
);
  localparam int W = 8 * OPERAND_BYTES;
  localparam logic [63:0] MASK = (W >= 64) ? '1 : ((64'd1 << W) - 64'd1);

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] remainder;
    logic        carry_out;
    logic [1:0]  order;
    logic        is_zero;
    logic        is_odd;
    logic        top_bit;
    logic        divide_by_zero;
  } alu_result_t;

  alu_result_t awaited_results[$];

  function automatic logic [63:0] rotl(logic [63:0] x, int c);
    return (c == 0) ? x : (((x << c) | (x >> (W - c))) & MASK);
  endfunction

  function automatic alu_result_t compute_alu(opcode_t op, logic [63:0] a, logic [63:0] b,
                                             logic [5:0] cnt);
    alu_result_t r;
    logic [64:0] wide;
    int c;
    r = '0;
    a = a & MASK;
    b = b & MASK;
    c = cnt % W;
    case (op)
      OP_ADD: begin
        wide = {1'b0, a} + {1'b0, b};
        r.value = wide[63:0] & MASK;
        r.carry_out = wide[W];
      end
      OP_SUB: begin
        r.value = (a - b) & MASK;
        r.carry_out = (a < b);
      end
      OP_MUL: r.value = (a * b) & MASK;
      OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          r.value = a / b;
          r.remainder = a % b;
        end
      end
      OP_CMP: r.order = (a < b) ? ORD_LT : ((a == b) ? ORD_EQ : ORD_GT);
      OP_AND: r.value = a & b;
      OP_OR: r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_NOT: r.value = ~a & MASK;
      OP_SHL: r.value = (cnt >= W) ? '0 : ((a << cnt) & MASK);
      OP_SHR: r.value = (cnt >= W) ? '0 : (a >> cnt);
      OP_ROL: r.value = rotl(a, c);
      OP_ROR: r.value = rotl(a, (c == 0) ? 0 : W - c);
      OP_INC: begin
        r.value = (a + 64'd1) & MASK;
        r.carry_out = (r.value == 0);
      end
      OP_DEC: begin
        r.value = (a - 64'd1) & MASK;
        r.carry_out = (a == 0);
      end
      default: begin
        r.is_zero = (a == 0);
        r.is_odd = a[0];
        r.top_bit = a[W-1];
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending = awaited_results.size();

  always @(posedge clk) begin
    alu_result_t e;
    if (rst_n) begin
      if (in_valid && !in_stall)
        awaited_results.push_back(compute_alu(opcode_t'(in_opcode), in_operand_a,
                                              in_operand_b, in_bit_count));
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = awaited_results.pop_front();
          compare_field("value", e.value, out_value);
          compare_field("remainder", e.remainder, out_remainder);
          compare_field("carry_out", e.carry_out, out_carry_out);
          compare_field("order", e.order, out_order);
          compare_field("is_zero", e.is_zero, out_is_zero);
          compare_field("is_odd", e.is_odd, out_is_odd);
          compare_field("top_bit", e.top_bit, out_top_bit);
          compare_field("divide_by_zero", e.divide_by_zero, out_divide_by_zero);
        end
      end
    end
  end
endmodule

[tb/multiprecision_integer_alu_tb.sv]
// Top of the multiprecision ALU testbench: clock, reset, directed and random requests,
// result-side stalls and the verdict. Depends on mia_pkg and the checker module.
`timescale 1ns / 1ps
module multiprecision_integer_alu_tb;
  import mia_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_opcode;
  logic [63:0] in_operand_a;
  logic [63:0] in_operand_b;
  logic [5:0]  in_bit_count;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value;
  logic [63:0] out_remainder;
  logic        out_carry_out;
  logic [1:0]  out_order;
  logic        out_is_zero;
  logic        out_is_odd;
  logic        out_top_bit;
  logic        out_divide_by_zero;
  int          fail_count;
  int          pending;
  bit          hold_receiver;
  bit          stim_done;

  multiprecision_integer_alu dut (.*);
  multiprecision_integer_alu_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  function automatic logic [63:0] random_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'(($urandom_range(0, 15)));
      4: return {32'h0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_request(opcode_t op, logic [63:0] a, logic [63:0] b, logic [5:0] cnt);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_bit_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Result side: random stalls, and one long hold-off while requests keep coming.
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
      end
      if (stim_done) out_stall <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_stall <= 1'b1;
      else if ($urandom_range(0, 40) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 150)) @(posedge clk);
      end else out_stall <= 1'b0;
    end
  end

  initial begin
    logic [63:0] a;
    logic [63:0] b;
    int timeout;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_bit_count = '0;
    hold_receiver = 1'b0;
    stim_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edge cases: carries, borrows, zero divisor, long shifts and rotates.
    send_request(OP_ADD, '1, 64'd1, 6'd0);
    send_request(OP_ADD, '0, '0, 6'd63);
    send_request(OP_SUB, '0, 64'd1, 6'd0);
    send_request(OP_SUB, '1, '1, 6'd0);
    send_request(OP_MUL, '1, '1, 6'd0);
    send_request(OP_DIV, 64'd1234567, '0, 6'd0);
    send_request(OP_DIV, '1, 64'd7, 6'd0);
    send_request(OP_DIV, 64'd3, '1, 6'd0);
    send_request(OP_CMP, 64'd5, 64'd6, 6'd0);
    send_request(OP_CMP, '1, '1, 6'd0);
    send_request(OP_CMP, '1, '0, 6'd0);
    send_request(OP_AND, 64'hF0F0_F0F0_F0F0_F0F0, '1, 6'd0);
    send_request(OP_OR, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 6'd0);
    send_request(OP_XOR, '1, 64'h5555_5555_5555_5555, 6'd0);
    send_request(OP_NOT, '0, '1, 6'd0);
    send_request(OP_SHL, '1, '0, 6'd63);
    send_request(OP_SHR, '1, '0, 6'd0);
    send_request(OP_ROL, 64'h8000_0000_0000_0001, '0, 6'd63);
    send_request(OP_ROR, 64'h8000_0000_0000_0001, '0, 6'd1);
    send_request(OP_ROR, 64'h0123_4567_89AB_CDEF, '0, 6'd0);
    send_request(OP_INC, '1, '0, 6'd0);
    send_request(OP_DEC, '0, '0, 6'd0);
    send_request(OP_TEST, '0, '0, 6'd0);
    send_request(OP_TEST, 64'h8000_0000_0000_0001, '0, 6'd0);
    idle_for(1);

    // The sender waits here until every result has come back.
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 450; i++) begin
      if (i == 150) hold_receiver = 1'b1;
      if (i == 300) begin
        idle_for(1);
        while (pending != 0) @(posedge clk);
      end
      a = random_operand();
      b = random_operand();
      send_request(opcode_t'($urandom_range(0, 15)), a, b, 6'($urandom_range(0, 63)));
      idle_for(gap_length());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    timeout = 0;
    while (pending != 0 && timeout < 100000) begin
      @(posedge clk);
      timeout++;
    end
    repeat (80) @(posedge clk);
    if (pending != 0) begin
      $display("status: fail");
    end else if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/mia_pkg.sv
sv/multiprecision_integer_alu.sv
tb/multiprecision_integer_alu_checker.sv
tb/multiprecision_integer_alu_tb.sv
